// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, register indexes, reset values, request types and the
// Q4.28 saturation function.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 28;
  localparam int PIX_W     = 10;
  localparam int IMG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam int MUL_IN_W  = COORD_W + 1;
  localparam int MUL_OUT_W = 64;
  localparam int DVD_W     = 43;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int SAT_W     = 45;

  localparam logic [MUL_OUT_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd5;

  localparam logic signed [COORD_W-1:0] X_MIN_RST = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] X_MAX_RST = 32'sd126164927;
  localparam logic signed [COORD_W-1:0] Y_MIN_RST = -32'sd300647711;
  localparam logic signed [COORD_W-1:0] Y_MAX_RST = 32'sd300647711;
  localparam logic [IMG_W-1:0]          IMG_RST   = 11'd400;
  localparam int                        ITER_RST  = 1000;

  typedef struct packed {
    logic                        en;
    logic signed [MUL_IN_W-1:0]  a;
    logic signed [MUL_IN_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [IMG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [COORD_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if ((&v[SAT_W-1:COORD_W-1]) || !(|v[SAT_W-1:COORD_W-1])) begin
      res = v[COORD_W-1:0];
    end else if (v[SAT_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- rtl/mandelbrot_escape_time_top.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit, top level
// Flow: each axis is mapped in turn (span, multiply, divide, add), then each
// orbit iteration runs the check, y*y, x*y and update states, a final limit
// or escape check follows, and the result is loaded into the output register.
// One pixel is in flight at a time: the input is stalled until its result is
// loaded, also while a finished result waits on a stalled output register.
// Reset: synchronous active-low rst_n restores the default view and limits.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top #(
  parameter int MAX_DIM    = 1024,
  parameter int COUNT_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mbe_pkg::PIX_W-1:0]      in_pixel_column,
  input  logic [mbe_pkg::PIX_W-1:0]      in_pixel_row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COUNT_BITS-1:0]          out_escape_count,
  output logic                           out_in_set
);
  import mbe_pkg::*;

  localparam int MAX_CLAMP = (MAX_DIM > (1 << IMG_W) - 1) ? (1 << IMG_W) - 1 : MAX_DIM;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPAN, ST_MAP_MUL, ST_DIV_START, ST_DIV_WAIT, ST_MAP_ADD,
    ST_CHECK, ST_MUL_YY, ST_MUL_XY, ST_UPDATE, ST_DONE
  } state_t;

  state_t                     state_r;
  logic signed [COORD_W-1:0]  x_min_r, x_max_r, y_min_r, y_max_r;
  logic [IMG_W-1:0]           image_size_r;
  logic [COUNT_BITS-1:0]      iteration_limit_r;

  logic [PIX_W-1:0]           col_r, row_r;
  logic [IMG_W-1:0]           size_r;
  logic [COUNT_BITS-1:0]      lim_r, iter_r;
  logic                       axis_r, neg_r, esc_r, in_set_r;
  logic signed [MUL_IN_W-1:0] span_r;
  logic signed [COORD_W-1:0]  c_re_r, c_im_r, x_r, y_r;
  logic signed [MUL_OUT_W-1:0] xx_r, diff_r;
  logic                       out_valid_r, out_in_set_r;
  logic [COUNT_BITS-1:0]      out_escape_count_r;

  mul_req_t                   mul_req;
  logic signed [MUL_OUT_W-1:0] p_r;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  logic                       in_xfer;
  logic [IMG_W-1:0]           size_clamped;
  logic signed [COORD_W-1:0]  lo, hi;
  logic [PIX_W-1:0]           pos;
  logic [MUL_OUT_W-1:0]       p_mag;
  logic signed [SAT_W-1:0]    lo_ext, q_ext, map_sum;
  logic signed [MUL_OUT_W-1:0] nx_shift, ny_shift;
  logic signed [SAT_W-1:0]    nx_sum, ny_sum;
  logic [MUL_OUT_W-1:0]       mag_sum;
  logic                       out_free;

  mbe_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .p_r (p_r)
  );

  mbe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r           <= X_MIN_RST;
      x_max_r           <= X_MAX_RST;
      y_min_r           <= Y_MIN_RST;
      y_max_r           <= Y_MAX_RST;
      image_size_r      <= IMG_RST;
      iteration_limit_r <= COUNT_BITS'(ITER_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_MIN:      x_min_r <= cfg_wdata;
        REG_X_MAX:      x_max_r <= cfg_wdata;
        REG_Y_MIN:      y_min_r <= cfg_wdata;
        REG_Y_MAX:      y_max_r <= cfg_wdata;
        REG_IMAGE_SIZE: image_size_r <= cfg_wdata[IMG_W-1:0];
        REG_ITER_LIMIT: iteration_limit_r <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (image_size_r == '0) begin
      size_clamped = IMG_W'(1);
    end else if (image_size_r > IMG_W'(MAX_CLAMP)) begin
      size_clamped = IMG_W'(MAX_CLAMP);
    end else begin
      size_clamped = image_size_r;
    end
  end

  assign lo  = axis_r ? y_min_r : x_min_r;
  assign hi  = axis_r ? y_max_r : x_max_r;
  assign pos = axis_r ? row_r : col_r;

  assign p_mag   = p_r[MUL_OUT_W-1] ? MUL_OUT_W'(-p_r) : MUL_OUT_W'(p_r);
  assign lo_ext  = SAT_W'(lo);
  assign q_ext   = $signed({{(SAT_W-DVD_W){1'b0}}, div_rsp.quotient});
  assign map_sum = neg_r ? lo_ext - q_ext : lo_ext + q_ext;

  assign mag_sum  = xx_r + p_r;
  assign nx_shift = diff_r >>> FRAC_BITS;
  assign ny_shift = p_r >>> (FRAC_BITS - 1);
  assign nx_sum   = nx_shift[SAT_W-1:0] + SAT_W'(c_re_r);
  assign ny_sum   = ny_shift[SAT_W-1:0] + SAT_W'(c_im_r);

  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = span_r;
    mul_req.b  = $signed({{(MUL_IN_W-PIX_W){1'b0}}, pos});
    case (state_r)
      ST_MAP_MUL: mul_req.en = 1'b1;
      ST_CHECK: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_IN_W'(x_r);
        mul_req.b  = MUL_IN_W'(x_r);
      end
      ST_MUL_YY: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_IN_W'(y_r);
        mul_req.b  = MUL_IN_W'(y_r);
      end
      ST_MUL_XY: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_IN_W'(x_r);
        mul_req.b  = MUL_IN_W'(y_r);
      end
      default: ;
    endcase
  end

  assign div_req.start    = (state_r == ST_DIV_START);
  assign div_req.dividend = p_mag[DVD_W-1:0];
  assign div_req.divisor  = size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      iter_r      <= '0;
      lim_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            col_r   <= in_pixel_column;
            row_r   <= in_pixel_row;
            size_r  <= size_clamped;
            lim_r   <= iteration_limit_r;
            axis_r  <= 1'b0;
            state_r <= ST_SPAN;
          end
        end
        ST_SPAN: begin
          span_r  <= MUL_IN_W'(hi) - MUL_IN_W'(lo);
          state_r <= ST_MAP_MUL;
        end
        ST_MAP_MUL: state_r <= ST_DIV_START;
        ST_DIV_START: begin
          neg_r   <= p_r[MUL_OUT_W-1];
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            state_r <= ST_MAP_ADD;
          end
        end
        ST_MAP_ADD: begin
          if (axis_r) begin
            c_im_r  <= sat_q(map_sum);
            x_r     <= '0;
            y_r     <= '0;
            iter_r  <= '0;
            state_r <= ST_CHECK;
          end else begin
            c_re_r  <= sat_q(map_sum);
            state_r <= ST_SPAN;
          end
          axis_r <= !axis_r;
        end
        ST_CHECK: begin
          if (iter_r >= lim_r) begin
            in_set_r <= 1'b1;
            state_r  <= ST_DONE;
          end else begin
            state_r  <= ST_MUL_YY;
          end
        end
        ST_MUL_YY: begin
          xx_r    <= p_r;
          state_r <= ST_MUL_XY;
        end
        ST_MUL_XY: begin
          esc_r   <= mag_sum >= ESCAPE_LIMIT;
          diff_r  <= xx_r - p_r;
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (esc_r) begin
            in_set_r <= 1'b0;
            state_r  <= ST_DONE;
          end else begin
            x_r     <= sat_q(nx_sum);
            y_r     <= sat_q(ny_sum);
            iter_r  <= iter_r + 1'b1;
            state_r <= ST_CHECK;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_escape_count_r <= iter_r;
            out_in_set_r       <= in_set_r;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_escape_count = out_escape_count_r;
  assign out_in_set       = out_in_set_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (iter_r <= lim_r))
    else $error("escape count exceeds the iteration limit");

  a_in_set_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && in_set_r) |-> (iter_r == lim_r))
    else $error("in-set result without a full iteration count");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_SPAN && !axis_r))
    else $error("accepted transfer did not start the mapping");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result was not loaded into the output register");

endmodule

// ----- rtl/mbe_mul.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot shared multiplier
// One signed 33x33 multiplier with a registered product, shared by the
// coordinate mapping and every orbit iteration.
// ----------------------------------------------------------------------------
module mbe_mul (
  input  logic                                 clk,
  input  mbe_pkg::mul_req_t                    req,
  output logic signed [mbe_pkg::MUL_OUT_W-1:0] p_r
);
  import mbe_pkg::*;

  logic signed [2*MUL_IN_W-1:0] full;

  assign full = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      p_r <= full[MUL_OUT_W-1:0];
    end
  end

endmodule

// ----- rtl/mbe_div.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot iterative divider
// Unsigned restoring divider, one quotient bit per cycle, used to scale the
// pixel offset by the image size.
// ----------------------------------------------------------------------------
module mbe_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mbe_pkg::div_req_t req,
  output mbe_pkg::div_rsp_t rsp
);
  import mbe_pkg::*;

  logic [DVD_W-1:0]     dvd_r;
  logic [IMG_W-1:0]     dsr_r;
  logic [IMG_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [IMG_W:0]       trial;
  logic                 ge;
  logic [IMG_W:0]       diff;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[IMG_W-1:0] : trial[IMG_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule
